// File: hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk, skip while reset is held.
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// Check a property at every rising edge of clk, reset included.
`define ASSERT_CLK_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/trrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package trrc_pkg;

	localparam int unsigned LETTERS = 26;

	typedef logic [4:0] letter_t;
	typedef letter_t tbl_t [LETTERS];

	// Rotor offsets, each already reduced to 0..25.
	typedef struct packed {
		letter_t off1;
		letter_t off2;
		letter_t off3;
	} offsets_t;

	localparam letter_t LAST_LETTER = letter_t'(LETTERS - 1);
	localparam letter_t WRAP = letter_t'(LETTERS);

	localparam tbl_t WIRING1 = '{5, 15, 16, 9, 7, 24, 10, 14, 20, 11, 13, 12, 3,
		0, 22, 23, 6, 18, 25, 8, 21, 2, 1, 17, 19, 4};
	localparam tbl_t WIRING2 = '{24, 21, 20, 15, 13, 1, 6, 22, 9, 23, 25, 10, 17,
		8, 0, 14, 11, 16, 5, 3, 18, 7, 12, 19, 4, 2};
	localparam tbl_t WIRING3 = '{19, 21, 7, 23, 17, 9, 6, 22, 18, 8, 24, 10, 0,
		11, 1, 2, 5, 12, 13, 16, 3, 20, 14, 25, 4, 15};
	localparam tbl_t REFLECT = '{13, 20, 23, 24, 15, 19, 21, 16, 22, 25, 17, 18,
		14, 0, 12, 4, 7, 10, 11, 5, 1, 6, 8, 2, 3, 9};

	// Build the backward table: last position holding each value, 0 if none.
	function automatic tbl_t invert(input tbl_t w);
		tbl_t r;
		for (int v = 0; v < LETTERS; v++) begin
			r[v] = '0;
			for (int i = 0; i < LETTERS; i++) begin
				if (w[i] == letter_t'(v)) begin
					r[v] = letter_t'(i);
				end
			end
		end
		return r;
	endfunction

	localparam tbl_t INVERSE1 = invert(WIRING1);
	localparam tbl_t INVERSE2 = invert(WIRING2);
	localparam tbl_t INVERSE3 = invert(WIRING3);

	// (a + b) mod 26 for a, b in 0..25.
	function automatic letter_t add_mod(input letter_t a, input letter_t b);
		logic [5:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= {1'b0, WRAP}) begin
			sum = sum - {1'b0, WRAP};
		end
		return sum[4:0];
	endfunction

	// (a - b) mod 26 for a, b in 0..25.
	function automatic letter_t sub_mod(input letter_t a, input letter_t b);
		letter_t d;
		if (a >= b) begin
			d = a - b;
		end else begin
			d = a + WRAP - b;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/trrc_rotor_counter.sv
`timescale 1ns / 1ps
`default_nettype none

module trrc_rotor_counter (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	output trrc_pkg::offsets_t      offsets
);

	trrc_pkg::letter_t count1_q;
	trrc_pkg::letter_t count2_q;
	trrc_pkg::letter_t count3_q;

	// Counts 1 and 2 run 0..26 and then restart at 1; count 3 wraps at 26.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count1_q <= '0;
			count2_q <= '0;
			count3_q <= '0;
		end else if (advance) begin
			if (count1_q == trrc_pkg::WRAP) begin
				count1_q <= 5'd1;
				if (count2_q == trrc_pkg::WRAP) begin
					count2_q <= 5'd1;
					if (count3_q == trrc_pkg::LAST_LETTER) begin
						count3_q <= '0;
					end else begin
						count3_q <= count3_q + 5'd1;
					end
				end else begin
					count2_q <= count2_q + 5'd1;
				end
			end else begin
				count1_q <= count1_q + 5'd1;
			end
		end
	end

	// A count of 26 acts as offset 0.
	assign offsets.off1 = (count1_q == trrc_pkg::WRAP) ? '0 : count1_q;
	assign offsets.off2 = (count2_q == trrc_pkg::WRAP) ? '0 : count2_q;
	assign offsets.off3 = count3_q;

endmodule

`default_nettype wire

// File: hw/rtl/trrc_scrambler.sv
`timescale 1ns / 1ps
`default_nettype none

module trrc_scrambler (
	input  wire trrc_pkg::letter_t  letter,
	input  wire trrc_pkg::offsets_t offsets,
	output trrc_pkg::letter_t       cipher
);

	trrc_pkg::letter_t fwd1;
	trrc_pkg::letter_t fwd2;
	trrc_pkg::letter_t fwd3;
	trrc_pkg::letter_t refl;
	trrc_pkg::letter_t bwd3;
	trrc_pkg::letter_t bwd2;

	// Forward through rotors 1..3, reflect, back through rotors 3..1.
	assign fwd1 = trrc_pkg::WIRING1[trrc_pkg::add_mod(letter, offsets.off1)];
	assign fwd2 = trrc_pkg::WIRING2[trrc_pkg::add_mod(fwd1, offsets.off2)];
	assign fwd3 = trrc_pkg::WIRING3[trrc_pkg::add_mod(fwd2, offsets.off3)];
	assign refl = trrc_pkg::REFLECT[fwd3];
	assign bwd3 = trrc_pkg::sub_mod(trrc_pkg::INVERSE3[refl], offsets.off3);
	assign bwd2 = trrc_pkg::sub_mod(trrc_pkg::INVERSE2[bwd3], offsets.off2);
	assign cipher = trrc_pkg::sub_mod(trrc_pkg::INVERSE1[bwd2], offsets.off1);

endmodule

`default_nettype wire

// File: hw/rtl/three_rotor_reflector_cipher.sv
// Three-rotor reflector cipher: one plain letter in, one cipher letter out.
//
// Input channel: letter_valid / letter_stall with plain_letter (0..25; codes
// 26..31 are reduced by 26 first). An item is taken on a rising edge where
// letter_valid is high and letter_stall is low.
// Output channel: cipher_valid / cipher_stall with cipher_letter (0..25).
//
// The letter and a snapshot of the rotor offsets are registered on accept; the
// combinational rotor path feeds the result register, which loads when free.
// The block takes one letter per cycle while the receiver does not stall; the
// combinational rotor path (three lookups, reflector, three backward lookups)
// sets the clock. The rotor counters step on every accepted letter.
//
// Reset (arst_n low) clears both pipeline stages and all rotor counters.
// When the receiver stalls, the result holds; if the input stage is empty, one
// more letter is taken into it, then letter_stall rises until the result moves on.
`timescale 1ns / 1ps
`default_nettype none

module three_rotor_reflector_cipher (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              letter_valid,
	output logic                   letter_stall,
	input  wire trrc_pkg::letter_t plain_letter,
	output logic                   cipher_valid,
	input  wire logic              cipher_stall,
	output trrc_pkg::letter_t      cipher_letter
);

	logic               take_in;
	logic               load_s2;
	logic               vld_s1;
	logic               vld_s2;
	trrc_pkg::letter_t  letter_s1;
	trrc_pkg::offsets_t offsets_s1;
	trrc_pkg::offsets_t offsets;
	trrc_pkg::letter_t  cipher;
	trrc_pkg::letter_t  cipher_s2;
	trrc_pkg::letter_t  letter_red;

	// Result register is free when empty or being taken this cycle.
	assign load_s2 = !vld_s2 || !cipher_stall;
	assign letter_stall = vld_s1 && !load_s2;
	assign take_in = letter_valid && !letter_stall;

	// Fold the six out-of-range codes onto A..F.
	assign letter_red = (plain_letter >= trrc_pkg::WRAP) ?
		plain_letter - trrc_pkg::WRAP : plain_letter;

	trrc_rotor_counter u_counter (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (take_in),
		.offsets (offsets)
	);

	// Input stage: hold the letter with the offsets it must be enciphered under.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take_in) begin
			vld_s1 <= 1'b1;
		end else if (load_s2) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			letter_s1 <= letter_red;
			offsets_s1 <= offsets;
		end
	end

	trrc_scrambler u_scrambler (
		.letter  (letter_s1),
		.offsets (offsets_s1),
		.cipher  (cipher)
	);

	// Result stage: advance when free, otherwise hold for the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (load_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && vld_s1) begin
			cipher_s2 <= cipher;
		end
	end

	assign cipher_valid = vld_s2;
	assign cipher_letter = cipher_s2;

endmodule

`default_nettype wire

// File: hw/rtl/trrc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module trrc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              letter_valid,
	input wire logic              letter_stall,
	input wire trrc_pkg::letter_t plain_letter,
	input wire logic              cipher_valid,
	input wire logic              cipher_stall,
	input wire trrc_pkg::letter_t cipher_letter
);

	logic              accept;
	trrc_pkg::letter_t plain_red;

	assign accept = letter_valid && !letter_stall;
	assign plain_red = (plain_letter >= trrc_pkg::WRAP) ?
		plain_letter - trrc_pkg::WRAP : plain_letter;

	// Reset empties the result register.
	`ASSERT_CLK_ALWAYS(a_reset_empty, !arst_n |-> !cipher_valid)

	// A stalled result stays valid and keeps its value.
	`ASSERT_CLK(a_hold, cipher_valid && cipher_stall |=>
		cipher_valid && $stable(cipher_letter))

	// Results are always letters.
	`ASSERT_CLK(a_in_range, cipher_valid |-> cipher_letter <= trrc_pkg::LAST_LETTER)

	// The reflector has no fixed point, so no letter enciphers to itself.
	`ASSERT_CLK(a_no_self, accept ##1 (!cipher_valid || !cipher_stall) |=>
		cipher_valid && cipher_letter != $past(plain_red, 2))

endmodule

bind three_rotor_reflector_cipher trrc_checker u_trrc_checker (.*);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

// Checks the three-rotor reflector cipher letter by letter. A local model of
// the rotor stack (its own wiring tables, rotor counts and carry chain) predicts
// the cipher letter for every accepted plain letter. The predictions queue up in
// order and are compared with each result the block hands out.
module testbench;

	typedef trrc_pkg::letter_t letter_t;

	localparam int ALPHABET    = 26;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 60;
	localparam int DRAIN_SLACK = 8;

	// Letters per random phase and for the closing back-to-back stream. The
	// middle rotor carries into the slow one after 703 letters from reset and
	// every 676 letters after that.
	localparam int SWEEP_LETTERS = 355;
	localparam int PHASE_LETTERS = 350;

	// Rotor and reflector wiring, fast rotor first.
	localparam int FAST_ROTOR [ALPHABET] = '{5, 15, 16, 9, 7, 24, 10, 14, 20, 11, 13,
		12, 3, 0, 22, 23, 6, 18, 25, 8, 21, 2, 1, 17, 19, 4};
	localparam int MIDDLE_ROTOR [ALPHABET] = '{24, 21, 20, 15, 13, 1, 6, 22, 9, 23,
		25, 10, 17, 8, 0, 14, 11, 16, 5, 3, 18, 7, 12, 19, 4, 2};
	localparam int SLOW_ROTOR [ALPHABET] = '{19, 21, 7, 23, 17, 9, 6, 22, 18, 8, 24,
		10, 0, 11, 1, 2, 5, 12, 13, 16, 3, 20, 14, 25, 4, 15};
	localparam int REFLECTOR [ALPHABET] = '{13, 20, 23, 24, 15, 19, 21, 16, 22, 25,
		17, 18, 14, 0, 12, 4, 7, 10, 11, 5, 1, 6, 8, 2, 3, 9};

	// One row of the directed table. Where known is set, the cipher letter is
	// typed in; otherwise the rotor model supplies it.
	typedef struct packed {
		letter_t plain;
		logic    known;
		letter_t cipher;
	} letter_row_t;

	// Start from reset: A enciphers to Q with all rotors at zero. Then the top of
	// the alphabet, every out-of-range code (folded back onto A..F), A, Z, N and
	// M, each bit set alone, all bits set, then 26, Z and A again.
	localparam int DIRECTED_ROWS = 21;
	localparam letter_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{5'd0,  1'b1, 5'd16},
		'{5'd25, 1'b0, 5'd0},
		'{5'd26, 1'b0, 5'd0},
		'{5'd27, 1'b0, 5'd0},
		'{5'd28, 1'b0, 5'd0},
		'{5'd29, 1'b0, 5'd0},
		'{5'd30, 1'b0, 5'd0},
		'{5'd31, 1'b0, 5'd0},
		'{5'd0,  1'b0, 5'd0},
		'{5'd25, 1'b0, 5'd0},
		'{5'd13, 1'b0, 5'd0},
		'{5'd12, 1'b0, 5'd0},
		'{5'd1,  1'b0, 5'd0},
		'{5'd2,  1'b0, 5'd0},
		'{5'd4,  1'b0, 5'd0},
		'{5'd8,  1'b0, 5'd0},
		'{5'd16, 1'b0, 5'd0},
		'{5'd31, 1'b0, 5'd0},
		'{5'd26, 1'b0, 5'd0},
		'{5'd25, 1'b0, 5'd0},
		'{5'd0,  1'b0, 5'd0}
	};

	logic    clk = 1'b0;
	logic    arst_n;
	logic    letter_valid = 1'b0;
	logic    letter_stall;
	letter_t plain_letter = '0;
	logic    cipher_valid;
	logic    cipher_stall = 1'b0;
	letter_t cipher_letter;

	// Model state: rotor counts and the backward wiring built from the tables.
	logic [4:0] fast_count;
	logic [4:0] middle_count;
	logic [4:0] slow_count;
	int         fast_back [ALPHABET];
	int         middle_back [ALPHABET];
	int         slow_back [ALPHABET];

	letter_t expected_ciphers [$];
	int      mismatch_count = 0;
	int      cycle_count = 0;

	// Receiver controls: stall percentage, plus a long hold-off on request.
	int stall_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	three_rotor_reflector_cipher dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.letter_valid (letter_valid),
		.letter_stall (letter_stall),
		.plain_letter (plain_letter),
		.cipher_valid (cipher_valid),
		.cipher_stall (cipher_stall),
		.cipher_letter(cipher_letter)
	);

	always #5 clk = ~clk;

	// Encipher one letter with the current rotor positions, then step the
	// rotors: the fast count runs 0..26 and carries into the middle one when it
	// passes 26, the middle count carries the same way, the slow count wraps.
	function automatic letter_t encipher_and_step(input letter_t plain);
		int x;
		int off_fast;
		int off_middle;
		int off_slow;
		off_fast = fast_count % ALPHABET;
		off_middle = middle_count % ALPHABET;
		off_slow = slow_count % ALPHABET;
		x = plain;
		// Fold codes 26..31 back onto A..F.
		if (x >= ALPHABET) begin
			x = x - ALPHABET;
		end
		x = FAST_ROTOR[(x + off_fast) % ALPHABET];
		x = MIDDLE_ROTOR[(x + off_middle) % ALPHABET];
		x = SLOW_ROTOR[(x + off_slow) % ALPHABET];
		x = REFLECTOR[x];
		x = (slow_back[x] + ALPHABET - off_slow) % ALPHABET;
		x = (middle_back[x] + ALPHABET - off_middle) % ALPHABET;
		x = (fast_back[x] + ALPHABET - off_fast) % ALPHABET;

		fast_count = fast_count + 5'd1;
		if (fast_count > 5'(ALPHABET)) begin
			fast_count = fast_count - 5'(ALPHABET);
			middle_count = middle_count + 5'd1;
			if (middle_count > 5'(ALPHABET)) begin
				middle_count = middle_count - 5'(ALPHABET);
				slow_count = (slow_count == 5'(ALPHABET - 1)) ? 5'd0 : slow_count + 5'd1;
			end
		end
		return letter_t'(x);
	endfunction

	// Mostly real letters, with a share of out-of-range codes.
	function automatic letter_t pick_letter();
		if ($urandom_range(99) < 85) begin
			return letter_t'($urandom_range(ALPHABET - 1));
		end
		return letter_t'($urandom_range(31, ALPHABET));
	endfunction

	// Offer one letter, starting at a falling edge. Idle for a random stretch
	// first, then hold the letter until the block takes it and queue what it
	// should come back as. Return at the next falling edge.
	task automatic offer_letter(input letter_t plain, input bit known,
			input letter_t known_cipher, input int idle_pct);
		letter_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			letter_valid <= 1'b0;
			@(negedge clk);
		end
		letter_valid <= 1'b1;
		plain_letter <= plain;
		do begin
			@(posedge clk);
		end while (!(letter_valid && !letter_stall));
		predicted = encipher_and_step(plain);
		expected_ciphers.push_back(known ? known_cipher : predicted);
		@(negedge clk);
	endtask

	// Stop offering and wait until every queued cipher letter has come back.
	task automatic drain_ciphers();
		letter_valid <= 1'b0;
		while (expected_ciphers.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic run_random_letters(input int count, input int idle_pct,
			input int stall_percent);
		stall_pct = stall_percent;
		repeat (count) begin
			offer_letter(pick_letter(), 1'b0, '0, idle_pct);
		end
	endtask

	// Receiver: drive the stall at each falling edge. A hold-off request wins
	// and keeps the output stalled until its countdown runs out.
	always @(negedge clk) begin
		if (!arst_n) begin
			cipher_stall <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			cipher_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			cipher_stall <= 1'b1;
		end else begin
			cipher_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Compare each accepted cipher letter with the oldest prediction.
	always @(posedge clk) begin : check_cipher
		letter_t want;
		if (arst_n && cipher_valid && !cipher_stall) begin
			if (expected_ciphers.size() == 0) begin
				mismatch_count++;
				$display("%0t: cipher_letter expected none, got %0d", $time,
					cipher_letter);
			end else begin
				want = expected_ciphers.pop_front();
				if (cipher_letter !== want) begin
					mismatch_count++;
					$display("%0t: cipher_letter expected %0d, got %0d", $time,
						want, cipher_letter);
				end
			end
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		// Drop reset with an edge the block sees.
		arst_n <= 1'b0;
		// Build the backward wiring; the last position holding a value wins.
		for (int i = 0; i < ALPHABET; i++) begin
			fast_back[FAST_ROTOR[i]] = i;
			middle_back[MIDDLE_ROTOR[i]] = i;
			slow_back[SLOW_ROTOR[i]] = i;
		end
		fast_count = '0;
		middle_count = '0;
		slow_count = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows, streamed back to back.
		stall_pct = 0;
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			offer_letter(DIRECTED[r].plain, DIRECTED[r].known, DIRECTED[r].cipher, 0);
		end
		drain_ciphers();

		// Hold the receiver off for a long stretch while letters keep coming, so
		// the pipeline fills and the block stalls its input.
		hold_request = 1'b1;
		repeat (24) begin
			offer_letter(pick_letter(), 1'b0, '0, 0);
		end
		drain_ciphers();

		// Random letters under each mix of idling and stalling; pause until empty between mixes.
		run_random_letters(PHASE_LETTERS, 0, 0);
		drain_ciphers();
		run_random_letters(PHASE_LETTERS, 75, 0);
		drain_ciphers();
		run_random_letters(PHASE_LETTERS, 0, 75);
		drain_ciphers();
		run_random_letters(PHASE_LETTERS, 26, 26);
		drain_ciphers();

		// Finish with one more back-to-back stream.
		run_random_letters(SWEEP_LETTERS, 0, 0);
		drain_ciphers();

		repeat (DRAIN_SLACK) @(posedge clk);
		if (mismatch_count == 0 && expected_ciphers.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
